// ===== sv/udw_pkg.sv =====
package udw_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_WANT_CLASS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WANT_SUBCLASS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WANT_PROTOCOL = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WANT_IN       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WANT_TYPE     = 3'd4;

  localparam int unsigned CfgDataW = 8;

  // Descriptor type codes
  localparam logic [7:0] DESC_TYPE_IFACE = 8'd4;
  localparam logic [7:0] DESC_TYPE_EP    = 8'd5;

  // Field offsets inside a descriptor
  localparam logic [15:0] OFF_LEN       = 16'd0;
  localparam logic [15:0] OFF_TYPE      = 16'd1;
  localparam logic [15:0] OFF_EP_ADDR   = 16'd2;
  localparam logic [15:0] OFF_EP_ATTR   = 16'd3;
  localparam logic [15:0] OFF_IF_CLASS  = 16'd5;
  localparam logic [15:0] OFF_IF_SUBCLS = 16'd6;
  localparam logic [15:0] OFF_IF_PROTO  = 16'd7;

  // Header byte positions of the total length
  localparam logic [15:0] POS_TOTLEN_LO = 16'd2;
  localparam logic [15:0] POS_TOTLEN_HI = 16'd3;
  localparam logic [15:0] POS_HDR_END   = 16'd4;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  // Endpoint address direction bit and attribute type mask
  localparam logic [7:0] EP_DIR_MASK  = 8'h80;
  localparam logic [7:0] EP_TYPE_MASK = 8'h03;

  typedef struct packed {
    logic [7:0] want_class;
    logic [7:0] want_subclass;
    logic [7:0] want_protocol;
    logic       want_in;
    logic [1:0] want_type;
  } udw_cfg_t;

  typedef struct packed {
    logic        iface_found;
    logic [15:0] iface_offset;
    logic        ep_found;
    logic [15:0] ep_offset;
    logic [7:0]  ep_address;
  } udw_result_t;

endpackage

// ===== sv/udw_intf.sv =====
interface udw_desc_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last;

  modport source (output valid, output desc_byte, output last, input ready);
  modport sink   (input valid, input desc_byte, input last, output ready);
endinterface

interface udw_res_if;
  logic        valid;
  logic        ready;
  logic        iface_found;
  logic [15:0] iface_offset;
  logic        ep_found;
  logic [15:0] ep_offset;
  logic [7:0]  ep_address;

  modport source (output valid, output iface_found, output iface_offset, output ep_found,
                  output ep_offset, output ep_address, input ready);
  modport sink   (input valid, input iface_found, input iface_offset, input ep_found,
                  input ep_offset, input ep_address, output ready);
endinterface

interface udw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [udw_pkg::CfgIdxW-1:0]  index;
  logic [udw_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/udw_cfg_regs.sv =====
module udw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [udw_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [udw_pkg::CfgDataW-1:0] wr_data_i,
  output udw_pkg::udw_cfg_t             cfg_o
);

  udw_pkg::udw_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        udw_pkg::CFG_WANT_CLASS:    cfg_d.want_class    = wr_data_i;
        udw_pkg::CFG_WANT_SUBCLASS: cfg_d.want_subclass = wr_data_i;
        udw_pkg::CFG_WANT_PROTOCOL: cfg_d.want_protocol = wr_data_i;
        udw_pkg::CFG_WANT_IN:       cfg_d.want_in       = wr_data_i[0];
        udw_pkg::CFG_WANT_TYPE:     cfg_d.want_type     = wr_data_i[1:0];
        default:                    cfg_d = cfg_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/udw_walker.sv =====
module udw_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [7:0]            desc_byte_i,
  input  logic                  last_i,
  input  udw_pkg::udw_cfg_t     cfg_i,
  output udw_pkg::udw_result_t  result_o
);

  typedef enum logic [1:0] {
    PH_IFACE,
    PH_EP,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] tot_len_q, tot_len_d;
  logic [15:0] start_q, start_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  kind_q, kind_d;
  logic        fmatch_q, fmatch_d;
  logic [15:0] if_pos_q, if_pos_d;
  logic [15:0] ep_pos_q, ep_pos_d;
  logic [7:0]  ep_addr_q, ep_addr_d;
  logic        if_hit_q, if_hit_d;
  logic        ep_hit_q, ep_hit_d;

  logic [15:0] off;
  logic        adv;
  logic        ep_dir;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    tot_len_d = tot_len_q;
    start_d   = start_q;
    len_d     = len_q;
    kind_d    = kind_q;
    fmatch_d  = fmatch_q;
    if_pos_d  = if_pos_q;
    ep_pos_d  = ep_pos_q;
    ep_addr_d = ep_addr_q;
    if_hit_d  = if_hit_q;
    ep_hit_d  = ep_hit_q;
    off       = pos_q - start_q;
    adv       = 1'b0;
    ep_dir    = |(desc_byte_i & udw_pkg::EP_DIR_MASK);
    result_o  = '0;

    if (take_i) begin
      if (pos_q == udw_pkg::POS_TOTLEN_LO) tot_len_d[7:0]  = desc_byte_i;
      if (pos_q == udw_pkg::POS_TOTLEN_HI) tot_len_d[15:8] = desc_byte_i;

      if (phase_q != PH_DONE) begin
        if (pos_q >= udw_pkg::POS_HDR_END && pos_q >= tot_len_q) begin
          phase_d = PH_DONE;
        end else begin
          adv = 1'b1;
          if (off == udw_pkg::OFF_LEN) begin
            len_d    = desc_byte_i;
            kind_d   = '0;
            fmatch_d = 1'b1;
            if (desc_byte_i == '0) begin
              phase_d = PH_DONE;
              adv     = 1'b0;
            end
          end else if (off == udw_pkg::OFF_TYPE) begin
            kind_d = desc_byte_i;
            if (phase_q == PH_EP && desc_byte_i == udw_pkg::DESC_TYPE_IFACE) begin
              phase_d = PH_DONE;
              adv     = 1'b0;
            end
          end else if (phase_q == PH_IFACE && kind_q == udw_pkg::DESC_TYPE_IFACE) begin
            if (off == udw_pkg::OFF_IF_CLASS && desc_byte_i != cfg_i.want_class)
              fmatch_d = 1'b0;
            if (off == udw_pkg::OFF_IF_SUBCLS && desc_byte_i != cfg_i.want_subclass)
              fmatch_d = 1'b0;
            if (off == udw_pkg::OFF_IF_PROTO && fmatch_q &&
                desc_byte_i == cfg_i.want_protocol) begin
              if_pos_d = start_q;
              if_hit_d = 1'b1;
              phase_d  = PH_EP;
            end
          end else if (phase_q == PH_EP && kind_q == udw_pkg::DESC_TYPE_EP) begin
            if (off == udw_pkg::OFF_EP_ADDR) begin
              ep_addr_d = desc_byte_i;
              if (ep_dir != cfg_i.want_in) fmatch_d = 1'b0;
            end
            if (off == udw_pkg::OFF_EP_ATTR && fmatch_q &&
                (desc_byte_i & udw_pkg::EP_TYPE_MASK) == {6'd0, cfg_i.want_type}) begin
              ep_pos_d = start_q;
              ep_hit_d = 1'b1;
              phase_d  = PH_DONE;
              adv      = 1'b0;
            end
          end

          // descriptor ends on this byte: next one starts on the following byte
          if (adv && ((17'(off) + 17'd1) >= 17'(len_d))) begin
            if (pos_q == udw_pkg::POS_MAX) phase_d = PH_DONE;
            else start_d = pos_q + 16'd1;
          end
        end
      end

      if (pos_q != udw_pkg::POS_MAX) pos_d = pos_q + 16'd1;

      result_o.iface_found  = if_hit_d;
      result_o.iface_offset = if_hit_d ? if_pos_d : '0;
      result_o.ep_found     = ep_hit_d;
      result_o.ep_offset    = ep_hit_d ? ep_pos_d : '0;
      result_o.ep_address   = ep_hit_d ? ep_addr_d : '0;

      if (last_i) begin
        phase_d   = PH_IFACE;
        pos_d     = '0;
        tot_len_d = '0;
        start_d   = '0;
        len_d     = '0;
        kind_d    = '0;
        fmatch_d  = 1'b1;
        if_pos_d  = '0;
        ep_pos_d  = '0;
        ep_addr_d = '0;
        if_hit_d  = 1'b0;
        ep_hit_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IFACE;
      pos_q     <= '0;
      tot_len_q <= '0;
      start_q   <= '0;
      len_q     <= '0;
      kind_q    <= '0;
      fmatch_q  <= 1'b1;
      if_pos_q  <= '0;
      ep_pos_q  <= '0;
      ep_addr_q <= '0;
      if_hit_q  <= 1'b0;
      ep_hit_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      tot_len_q <= tot_len_d;
      start_q   <= start_d;
      len_q     <= len_d;
      kind_q    <= kind_d;
      fmatch_q  <= fmatch_d;
      if_pos_q  <= if_pos_d;
      ep_pos_q  <= ep_pos_d;
      ep_addr_q <= ep_addr_d;
      if_hit_q  <= if_hit_d;
      ep_hit_q  <= ep_hit_d;
    end
  end

endmodule

// ===== sv/usb_descriptor_walker.sv =====
// USB configuration descriptor walker.
// desc_i: one descriptor byte per beat, with last on the final byte of a block.
// res_o:  one beat per block, on the byte marked last: interface match flag and
//         offset, endpoint match flag, offset and address (zeros when not found).
// cfg_i:  register writes (index 0..4: class, subclass, protocol, direction,
//         transfer type); always ready; write only while the walker is idle (unchecked).
// Path: an accepted byte is registered in the input register and then walked;
// walking a last byte loads its result beat into the result register.
// Throughput: one byte per cycle; the per-byte update is a handful of compares
// and a 16-bit offset subtract between the input register and walker state.
// Stall: the result register holds its beat while res_o.ready is low; bytes
// without last keep flowing, and only a last byte waits in the input register
// for the result slot, which then backs up desc_i.ready.
// Reset: walk state clears, configuration registers return to zero, no beat
// is pending. After each last byte the walk state clears for the next block.
module usb_descriptor_walker (
  input  logic  clk_i,
  input  logic  rst_ni,
  udw_desc_if.sink   desc_i,
  udw_res_if.source  res_o,
  udw_cfg_if.sink    cfg_i
);

  udw_pkg::udw_cfg_t    cfg;
  udw_pkg::udw_result_t res_d, res_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       s1_fire;
  logic       out_free;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  udw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // ---------------------------------------------------------------------------
  // Handshake: input register advances unless a last byte needs a busy slot
  // ---------------------------------------------------------------------------
  assign out_free     = !out_valid_q || res_o.ready;
  assign s1_fire      = in_valid_q && (!in_last_q || out_free);
  assign desc_i.ready = !in_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (desc_i.ready) begin
      in_valid_q <= desc_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_i.ready && desc_i.valid) begin
      in_byte_q <= desc_i.desc_byte;
      in_last_q <= desc_i.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Descriptor chain walker
  // ---------------------------------------------------------------------------
  udw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (s1_fire),
    .desc_byte_i (in_byte_q),
    .last_i      (in_last_q),
    .cfg_i       (cfg),
    .result_o    (res_d)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.iface_found  = res_q.iface_found;
  assign res_o.iface_offset = res_q.iface_offset;
  assign res_o.ep_found     = res_q.ep_found;
  assign res_o.ep_offset    = res_q.ep_offset;
  assign res_o.ep_address   = res_q.ep_address;

`ifndef SYNTHESIS
  // An endpoint is only searched for after an interface matched.
  a_ep_needs_iface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ep_found |-> res_q.iface_found)
    else $error("endpoint reported without interface");

  // The endpoint descriptor lies after its interface descriptor.
  a_ep_after_iface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.ep_found |-> res_q.ep_offset > res_q.iface_offset)
    else $error("endpoint offset not after interface offset");

  // Input backs up only for a last byte facing a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !desc_i.ready |-> (in_valid_q && in_last_q && out_valid_q && !res_o.ready))
    else $error("input stalled without cause");

  // A walked last byte always lands in the result register.
  a_last_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && in_last_q |=> out_valid_q)
    else $error("last byte lost its result");
`endif

endmodule
